// File: hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared definitions for the matrix-to-quaternion pipeline
// Field widths, default parameter values and the branch codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 30;
	localparam int ZERO_TOL_DEF  = 1;

	// the largest normalized magnitude sits in [2^30, 2^31)
	localparam int MAG_W  = 31;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = 64;
	localparam int ROOT_W = SUM_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

endpackage

// File: hw/rtl/rmq_in_if.sv
// ----------------------------------------------------------------------------
// rmq_in_if: matrix input channel
// Valid/ready channel carrying the nine matrix entries.
// ----------------------------------------------------------------------------
interface rmq_in_if import rmq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] r00;
	logic signed [DATA_W-1:0] r01;
	logic signed [DATA_W-1:0] r02;
	logic signed [DATA_W-1:0] r10;
	logic signed [DATA_W-1:0] r11;
	logic signed [DATA_W-1:0] r12;
	logic signed [DATA_W-1:0] r20;
	logic signed [DATA_W-1:0] r21;
	logic signed [DATA_W-1:0] r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
	modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

// File: hw/rtl/rmq_out_if.sv
// ----------------------------------------------------------------------------
// rmq_out_if: quaternion output channel
// Valid/ready channel carrying the unit quaternion and the zero-norm flag.
// ----------------------------------------------------------------------------
interface rmq_out_if import rmq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] qw;
	logic signed [DATA_W-1:0] qx;
	logic signed [DATA_W-1:0] qy;
	logic signed [DATA_W-1:0] qz;
	logic                     zero_norm;

	modport source (output valid, qw, qx, qy, qz, zero_norm, input ready);
	modport sink   (input valid, qw, qx, qy, qz, zero_norm, output ready);
endinterface

// File: hw/rtl/rotation_matrix_to_quaternion.sv
// Matrix entries and quaternion components are Q2.30 at the default FRAC_BITS.
// Throughput: one beat per cycle unless stalled; the square root takes one
// result bit and each divider one quotient bit per stage, fully pipelined.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd matrix-to-quaternion pipeline
// Branch select, magnitude normalization, sum of squares, bitwise integer
// square root and four restoring dividers with rounding and saturation.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int ZERO_TOLERANCE = ZERO_TOL_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rmq_in_if.sink   in_ch,
	rmq_out_if.source out_ch
);

	localparam int PW    = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 3;
	localparam int NG    = (PW + 7) / 8;
	localparam int POS_W = $clog2(NG * 8);
	localparam int QW    = FRAC_BITS + 2;
	localparam int NDIV  = FRAC_BITS + 1;
	localparam int CW    = (QW > 33) ? QW : 33;
	localparam logic [PW-1:0] ONE_V = PW'(1) << FRAC_BITS;

	logic en;
	assign en          = out_ch.ready || !out_ch.valid;
	assign in_ch.ready = en;

	// ---------------- stage 1: branch and scaled quaternion ----------------
	logic signed [PW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr;
	logic signed [PW-1:0] p_c [4];
	logic                 degen_c;
	branch_t              br;

	always_comb begin
		e00 = PW'(in_ch.r00); e01 = PW'(in_ch.r01); e02 = PW'(in_ch.r02);
		e10 = PW'(in_ch.r10); e11 = PW'(in_ch.r11); e12 = PW'(in_ch.r12);
		e20 = PW'(in_ch.r20); e21 = PW'(in_ch.r21); e22 = PW'(in_ch.r22);
		tr  = e00 + e11 + e22;
		if (tr > 0)
			br = BR_TRACE;
		else if (in_ch.r00 > in_ch.r11 && in_ch.r00 > in_ch.r22)
			br = BR_X;
		else if (in_ch.r11 > in_ch.r00 && in_ch.r11 > in_ch.r22)
			br = BR_Y;
		else
			br = BR_Z;
		case (br)
			BR_TRACE: begin
				p_c[0] = $signed(ONE_V) + tr;
				p_c[1] = e21 - e12;
				p_c[2] = e02 - e20;
				p_c[3] = e10 - e01;
				degen_c = 1'b0;
			end
			BR_X: begin
				p_c[0] = e21 - e12;
				p_c[1] = $signed(ONE_V) + e00 - e11 - e22;
				p_c[2] = e01 + e10;
				p_c[3] = e02 + e20;
				degen_c = p_c[1] <= 0;
			end
			BR_Y: begin
				p_c[0] = e02 - e20;
				p_c[1] = e01 + e10;
				p_c[2] = $signed(ONE_V) + e11 - e00 - e22;
				p_c[3] = e12 + e21;
				degen_c = p_c[2] <= 0;
			end
			default: begin
				p_c[0] = e10 - e01;
				p_c[1] = e02 + e20;
				p_c[2] = e12 + e21;
				p_c[3] = $signed(ONE_V) + e22 - e00 - e11;
				degen_c = p_c[3] <= 0;
			end
		endcase
	end

	logic                 v_s1, degen_s1;
	logic signed [PW-1:0] p_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= p_c;
			degen_s1 <= degen_c;
		end
	end

	// ---------------- stage 2: sign and magnitude ----------------
	logic          v_s2, degen_s2;
	logic [PW-1:0] mag_s2 [4];
	logic [3:0]    neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s2[i] <= p_s1[i][PW-1];
				mag_s2[i] <= p_s1[i][PW-1] ? PW'(-p_s1[i]) : PW'(p_s1[i]);
			end
			degen_s2 <= degen_s1;
		end
	end

	// ---------------- stage 3/4: largest magnitude ----------------
	logic          v_s3, degen_s3, v_s4, zero_s4;
	logic [PW-1:0] mag_s3 [4], mag_s4 [4];
	logic [3:0]    neg_s3, neg_s4;
	logic [PW-1:0] m01_s3, m23_s3, mx_s4, mx_c;

	assign mx_c = (m01_s3 > m23_s3) ? m01_s3 : m23_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m01_s3   <= (mag_s2[0] > mag_s2[1]) ? mag_s2[0] : mag_s2[1];
			m23_s3   <= (mag_s2[2] > mag_s2[3]) ? mag_s2[2] : mag_s2[3];
			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;
			degen_s3 <= degen_s2;
			mx_s4    <= mx_c;
			zero_s4  <= degen_s3 || (mx_c <= PW'(ZERO_TOLERANCE));
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;
		end
	end

	// ---------------- stage 5/6: leading-one search ----------------
	logic [NG*8-1:0] mxp;
	logic [NG-1:0]   gnz_c;
	logic [2:0]      gpos_c [NG];

	assign mxp = (NG * 8)'(mx_s4);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gnz_c[g]  = |mxp[g*8 +: 8];
			gpos_c[g] = 3'd0;
			for (int b = 0; b < 8; b++)
				if (mxp[g*8 + b])
					gpos_c[g] = 3'(b);
		end
	end

	logic          v_s5, zero_s5, v_s6, zero_s6;
	logic [PW-1:0] mag_s5 [4], mag_s6 [4];
	logic [3:0]    neg_s5, neg_s6;
	logic [NG-1:0] gnz_s5;
	logic [2:0]    gpos_s5 [NG];
	logic [POS_W-1:0] pos_c, pos_s6;

	always_comb begin
		pos_c = '0;
		for (int g = 0; g < NG; g++)
			if (gnz_s5[g])
				pos_c = POS_W'(g * 8) + POS_W'(gpos_s5[g]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gnz_s5  <= gnz_c;
			gpos_s5 <= gpos_c;
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			pos_s6  <= pos_c;
			mag_s6  <= mag_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// ---------------- stage 7: common shift into [2^30, 2^31) ----------------
	logic             v_s7, zero_s7;
	logic [MAG_W-1:0] mag_s7 [4];
	logic [3:0]       neg_s7;
	logic [POS_W-1:0] sh_c;
	logic             right_c;

	assign right_c = pos_s6 > POS_W'(MAG_W - 1);
	assign sh_c    = right_c ? (pos_s6 - POS_W'(MAG_W - 1)) : (POS_W'(MAG_W - 1) - pos_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				mag_s7[i] <= right_c ? MAG_W'(mag_s6[i] >> sh_c) : MAG_W'(mag_s6[i] << sh_c);
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
		end
	end

	// ---------------- stage 8..10: sum of squares ----------------
	logic             v_s8, zero_s8, v_s9, zero_s9;
	logic [SQ_W-1:0]  sq_s8 [4];
	logic [SQ_W:0]    s01_s9, s23_s9;
	logic [MAG_W-1:0] mag_s8 [4], mag_s9 [4];
	logic [3:0]       neg_s8, neg_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				sq_s8[i] <= SQ_W'(mag_s7[i]) * SQ_W'(mag_s7[i]);
			mag_s8  <= mag_s7;
			neg_s8  <= neg_s7;
			zero_s8 <= zero_s7;
			s01_s9  <= (SQ_W + 1)'(sq_s8[0]) + (SQ_W + 1)'(sq_s8[1]);
			s23_s9  <= (SQ_W + 1)'(sq_s8[2]) + (SQ_W + 1)'(sq_s8[3]);
			mag_s9  <= mag_s8;
			neg_s9  <= neg_s8;
			zero_s9 <= zero_s8;
		end
	end

	// ---------------- square root: element 0 is stage 10 ----------------
	logic             rt_v_sk    [0:ROOT_W];
	logic             rt_zero_sk [0:ROOT_W];
	logic [SUM_W-1:0] rt_sum_sk  [0:ROOT_W];
	logic [REM_W-1:0] rt_rem_sk  [0:ROOT_W];
	logic [ROOT_W-1:0] rt_root_sk [0:ROOT_W];
	logic [MAG_W-1:0] rt_mag_sk  [0:ROOT_W][4];
	logic [3:0]       rt_neg_sk  [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_sk[0] <= 1'b0;
		end else if (en) begin
			rt_v_sk[0] <= v_s9;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rt_sum_sk[0]  <= SUM_W'(s01_s9) + SUM_W'(s23_s9);
			rt_rem_sk[0]  <= '0;
			rt_root_sk[0] <= '0;
			rt_mag_sk[0]  <= mag_s9;
			rt_neg_sk[0]  <= neg_s9;
			rt_zero_sk[0] <= zero_s9;
		end
	end

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
		logic [REM_W+1:0] rem_sh, trial;
		logic             take;

		// bring down the next pair of radicand bits
		assign rem_sh = {rt_rem_sk[k-1], rt_sum_sk[k-1][SUM_W-2*k +: 2]};
		assign trial  = (REM_W + 2)'({rt_root_sk[k-1], 2'b01});
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_sk[k] <= 1'b0;
			end else if (en) begin
				rt_v_sk[k] <= rt_v_sk[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_sk[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				rt_root_sk[k] <= {rt_root_sk[k-1][ROOT_W-2:0], take};
				rt_sum_sk[k]  <= rt_sum_sk[k-1];
				rt_mag_sk[k]  <= rt_mag_sk[k-1];
				rt_neg_sk[k]  <= rt_neg_sk[k-1];
				rt_zero_sk[k] <= rt_zero_sk[k-1];
			end
		end
	end

	// ---------------- dividers: element 0 forms the integer bit ----------------
	logic              dv_v_sk    [0:NDIV];
	logic              dv_zero_sk [0:NDIV];
	logic [ROOT_W-1:0] dv_norm_sk [0:NDIV];
	logic [ROOT_W-1:0] dv_rem_sk  [0:NDIV][4];
	logic [QW-1:0]     dv_q_sk    [0:NDIV][4];
	logic [3:0]        dv_neg_sk  [0:NDIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_sk[0] <= 1'b0;
		end else if (en) begin
			dv_v_sk[0] <= rt_v_sk[ROOT_W];
		end
	end
	always_ff @(posedge clk) begin
		logic [ROOT_W-1:0] m;
		logic              ge;
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				m  = ROOT_W'(rt_mag_sk[ROOT_W][i]);
				ge = m >= rt_root_sk[ROOT_W];
				dv_rem_sk[0][i] <= ge ? m - rt_root_sk[ROOT_W] : m;
				dv_q_sk[0][i]   <= QW'(ge);
			end
			dv_norm_sk[0] <= rt_root_sk[ROOT_W];
			dv_neg_sk[0]  <= rt_neg_sk[ROOT_W];
			dv_zero_sk[0] <= rt_zero_sk[ROOT_W];
		end
	end

	for (genvar j = 1; j <= NDIV; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_sk[j] <= 1'b0;
			end else if (en) begin
				dv_v_sk[j] <= dv_v_sk[j-1];
			end
		end
		always_ff @(posedge clk) begin
			logic [ROOT_W:0] r2, nd;
			logic            ge;
			if (en) begin
				nd = {1'b0, dv_norm_sk[j-1]};
				for (int i = 0; i < 4; i++) begin
					r2 = {dv_rem_sk[j-1][i], 1'b0};
					ge = r2 >= nd;
					dv_rem_sk[j][i] <= ge ? ROOT_W'(r2 - nd) : ROOT_W'(r2);
					dv_q_sk[j][i]   <= {dv_q_sk[j-1][i][QW-2:0], ge};
				end
				dv_norm_sk[j] <= dv_norm_sk[j-1];
				dv_neg_sk[j]  <= dv_neg_sk[j-1];
				dv_zero_sk[j] <= dv_zero_sk[j-1];
			end
		end
	end

	// ---------------- output register: round, sign, saturate ----------------
	logic [DATA_W-1:0] res_c [4];

	always_comb begin
		logic [CW-1:0] qr;
		for (int i = 0; i < 4; i++) begin
			// last quotient bit is the rounding bit
			qr = CW'(dv_q_sk[NDIV][i][QW-1:1]) + CW'(dv_q_sk[NDIV][i][0]);
			if (!dv_neg_sk[NDIV][i]) begin
				res_c[i] = (qr > CW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qr[DATA_W-1:0];
			end else begin
				res_c[i] = (qr > CW'(33'h0_8000_0000)) ? 32'h8000_0000 : -qr[DATA_W-1:0];
			end
			if (dv_zero_sk[NDIV])
				res_c[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= dv_v_sk[NDIV];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.qw        <= res_c[0];
			out_ch.qx        <= res_c[1];
			out_ch.qy        <= res_c[2];
			out_ch.qz        <= res_c[3];
			out_ch.zero_norm <= dv_zero_sk[NDIV];
		end
	end

`ifndef SYNTHESIS
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.zero_norm |->
		out_ch.qw == 0 && out_ch.qx == 0 && out_ch.qy == 0 && out_ch.qz == 0)
		else $error("zero_norm beat carries a nonzero quaternion");

	a_unit_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.zero_norm |->
		(out_ch.qw | out_ch.qx | out_ch.qy | out_ch.qz) != 0)
		else $error("normalized quaternion came out all zero");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		rt_v_sk[ROOT_W] && !rt_zero_sk[ROOT_W] |->
		(66'(rt_root_sk[ROOT_W]) * 66'(rt_root_sk[ROOT_W]) <= 66'(rt_sum_sk[ROOT_W])) &&
		((66'(rt_root_sk[ROOT_W]) + 66'd1) * (66'(rt_root_sk[ROOT_W]) + 66'd1) >
		 66'(rt_sum_sk[ROOT_W])))
		else $error("square root stage result is not the floor root");

	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_sk[0] && !dv_zero_sk[0] |->
		dv_norm_sk[0] >= ROOT_W'(32'h4000_0000))
		else $error("norm below the largest normalized magnitude");
`endif

endmodule
